// ===== rtl/core/erfc_pkg.sv =====
// ----------------------------------------------------------------------------
// erfc_pkg
// Shared types, constants and the bytewise crc step for the receive ring
// frame checker.
// ----------------------------------------------------------------------------
package erfc_pkg;

  // ring size in bytes, a power of two
  localparam int unsigned RING_BYTES = 8192;
  localparam int unsigned RING_W     = $clog2(RING_BYTES);

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
  localparam logic [15:0] RP_BIAS   = 16'h0010;
  localparam logic [15:0] MIN_FRAME = 16'd18;
  localparam logic [16:0] HDR_BYTES = 17'd4;

  typedef enum logic [2:0] {
    VD_ACCEPT = 3'd0,
    VD_CRC    = 3'd1,
    VD_ADDR   = 3'd2,
    VD_EMPTY  = 3'd3,
    VD_RUNT   = 3'd4
  } verdict_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/ethernet_rx_ring_frame_check_core.sv =====
// ----------------------------------------------------------------------------
// ethernet_rx_ring_frame_check_core
// Receive ring record checker: crc-32 check, address filter, ring advance.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one ring record byte per transfer: a 4-byte
//   little-endian header (frame length in bytes 2 and 3) and then the frame.
//   out_valid/out_ready carry one verdict per record, with ether type,
//   payload length, broadcast flag, next ring offset and read pointer.
//   cfg_wr_en/cfg_wr_data write the station mac while the block is idle.
// Latency: a byte is processed in the cycle after its transfer, while it
//   sits in the input register; the verdict of a record's last byte is
//   registered onto out_*, held back while the result register is full.
// Throughput: one byte per cycle unless a record's last byte waits for the result
//   register, set by the crc step between input register and state registers;
//   at most one verdict per four record bytes (empty records). Stall: while a
//   verdict waits for out_ready, the input register still takes header and frame
//   bytes that produce no verdict; only the byte that ends a record holds until the result register frees.
// Reset: record state restarts, ring offset and station mac go to zero,
//   both channels are empty.
// ----------------------------------------------------------------------------
module ethernet_rx_ring_frame_check_core
  import erfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_record_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_verdict,
  output logic [15:0] out_ether_type,
  output logic [15:0] out_payload_length,
  output logic        out_dest_broadcast,
  output logic [15:0] out_next_ring_offset,
  output logic [15:0] out_read_pointer
);

  logic [47:0]       mac_r;
  logic              stg_valid_r;
  logic [7:0]        stg_byte_r;

  logic [16:0]       pos_r, pos_nxt;
  logic [15:0]       flen_r, flen_nxt;
  logic [31:0]       crc_r, crc_nxt;
  logic [31:0]       trail_r, trail_nxt;
  logic              deq_r, deq_nxt;
  logic              dall_r, dall_nxt;
  logic [15:0]       etype_r, etype_nxt;
  logic [RING_W-1:0] roff_r, roff_nxt;

  logic              out_valid_r;
  verdict_t          vd_r, vd_nxt;
  logic [15:0]       et_r, et_nxt;
  logic [15:0]       pl_r, pl_nxt;
  logic              bc_r, bc_nxt;
  logic [15:0]       nro_r, nro_nxt;
  logic [15:0]       rp_r, rp_nxt;

  logic              emit;
  logic              restart;
  logic              advance;
  logic [16:0]       idx;
  logic [16:0]       flen17;
  logic [15:0]       hlen;
  logic [5:0]        mac_sh;
  logic [7:0]        own;
  logic [17:0]       unwr_sum;
  logic [17:0]       unwr;

  always_comb begin
    pos_nxt   = pos_r;
    flen_nxt  = flen_r;
    crc_nxt   = crc_r;
    trail_nxt = trail_r;
    deq_nxt   = deq_r;
    dall_nxt  = dall_r;
    etype_nxt = etype_r;
    roff_nxt  = roff_r;
    vd_nxt    = VD_EMPTY;
    et_nxt    = '0;
    pl_nxt    = '0;
    bc_nxt    = 1'b0;
    nro_nxt   = 16'(roff_r);
    rp_nxt    = 16'(roff_r) - RP_BIAS;
    emit      = 1'b0;
    restart   = 1'b0;
    idx       = pos_r - HDR_BYTES;
    flen17    = {1'b0, flen_r};
    hlen      = flen_r;
    mac_sh    = {3'd5 - idx[2:0], 3'b000};
    own       = 8'(mac_r >> mac_sh);
    unwr_sum  = 18'(roff_r) + 18'(flen_r) + 18'd7;
    unwr      = {unwr_sum[17:2], 2'b00};

    if (stg_valid_r) begin
      if (pos_r < HDR_BYTES) begin
        if (pos_r[1:0] == 2'd2) begin
          hlen = {8'h00, stg_byte_r};
        end else if (pos_r[1:0] == 2'd3) begin
          hlen = {stg_byte_r, flen_r[7:0]};
        end
        flen_nxt = hlen;
        pos_nxt  = pos_r + 17'd1;
        if (pos_r[1:0] == 2'd3 && hlen == 16'd0) begin
          emit    = 1'b1;
          restart = 1'b1;
        end
      end else begin
        if (flen_r >= 16'd4 && idx < flen17 - 17'd4) begin
          crc_nxt = crc_byte(crc_r, stg_byte_r);
        end
        if (idx < 17'd6) begin
          if (stg_byte_r != own) deq_nxt = 1'b0;
          if (stg_byte_r != 8'hFF) dall_nxt = 1'b0;
        end
        if (idx == 17'd12) begin
          etype_nxt = {stg_byte_r, 8'h00};
        end else if (idx == 17'd13) begin
          etype_nxt = {etype_r[15:8], stg_byte_r};
        end
        trail_nxt = {stg_byte_r, trail_r[31:8]};
        pos_nxt   = pos_r + 17'd1;
        if (idx + 17'd1 >= flen17) begin
          emit    = 1'b1;
          restart = 1'b1;
          nro_nxt = 16'(unwr[RING_W-1:0]);
          rp_nxt  = unwr[15:0] - RP_BIAS;
          if (flen_r < MIN_FRAME) begin
            vd_nxt = VD_RUNT;
          end else begin
            priority if ((crc_nxt ^ CRC_ONES) != trail_nxt) begin
              vd_nxt = VD_CRC;
            end else if (!dall_nxt && !deq_nxt) begin
              vd_nxt = VD_ADDR;
            end else begin
              vd_nxt = VD_ACCEPT;
            end
            et_nxt = etype_nxt;
            pl_nxt = flen_r - MIN_FRAME;
            bc_nxt = dall_nxt;
          end
          roff_nxt = unwr[RING_W-1:0];
        end
      end
    end

    if (restart) begin
      pos_nxt   = '0;
      flen_nxt  = '0;
      crc_nxt   = CRC_ONES;
      trail_nxt = '0;
      deq_nxt   = 1'b1;
      dall_nxt  = 1'b1;
      etype_nxt = '0;
    end
  end

  assign advance  = stg_valid_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_r       <= '0;
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      flen_r      <= '0;
      crc_r       <= CRC_ONES;
      trail_r     <= '0;
      deq_r       <= 1'b1;
      dall_r      <= 1'b1;
      etype_r     <= '0;
      roff_r      <= '0;
    end else begin
      if (cfg_wr_en) mac_r <= cfg_wr_data;
      if (in_ready) stg_valid_r <= in_valid;
      if (advance && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (advance) begin
        pos_r   <= pos_nxt;
        flen_r  <= flen_nxt;
        crc_r   <= crc_nxt;
        trail_r <= trail_nxt;
        deq_r   <= deq_nxt;
        dall_r  <= dall_nxt;
        etype_r <= etype_nxt;
        roff_r  <= roff_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stg_byte_r <= in_record_byte;
    if (advance && emit) begin
      vd_r  <= vd_nxt;
      et_r  <= et_nxt;
      pl_r  <= pl_nxt;
      bc_r  <= bc_nxt;
      nro_r <= nro_nxt;
      rp_r  <= rp_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = vd_r;
  assign out_ether_type       = et_r;
  assign out_payload_length   = pl_r;
  assign out_dest_broadcast   = bc_r;
  assign out_next_ring_offset = nro_r;
  assign out_read_pointer     = rp_r;

endmodule

// ===== rtl/core/erfc_checker.sv =====
// ----------------------------------------------------------------------------
// erfc_checker
// Port-level checks on the verdict channel of the frame checker core.
// ----------------------------------------------------------------------------
module erfc_checker
  import erfc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_verdict,
  input logic [15:0] out_ether_type,
  input logic [15:0] out_payload_length,
  input logic        out_dest_broadcast,
  input logic [15:0] out_next_ring_offset,
  input logic [15:0] out_read_pointer
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_verdict)
      && $stable(out_next_ring_offset) && $stable(out_read_pointer))
    else $error("stalled verdict changed");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_verdict <= VD_RUNT)
    else $error("verdict code out of range");

  // no frame data for empty or runt records
  a_short_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VD_EMPTY || out_verdict == VD_RUNT)
      |-> out_ether_type == 16'd0 && out_payload_length == 16'd0 && !out_dest_broadcast)
    else $error("fields set on empty or runt verdict");

  a_ring_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_next_ring_offset[1:0] == 2'b00
      && {1'b0, out_next_ring_offset} < 17'(RING_BYTES))
    else $error("ring offset unaligned or beyond ring");

  a_empty_pointer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VD_EMPTY
      |-> out_read_pointer == out_next_ring_offset - RP_BIAS)
    else $error("read pointer mismatch on empty record");

endmodule

bind ethernet_rx_ring_frame_check_core erfc_checker u_erfc_checker (.*);

// ===== dv/tb_ethernet_rx_ring_frame_check_core.sv =====
// ----------------------------------------------------------------------------
// tb_ethernet_rx_ring_frame_check_core
// Streams receive ring records into the frame checker byte by byte and
// compares every verdict with a byte-level predictor. The predictor tracks
// the crc, the address filter, the ether type and the ring offset. Directed
// records cover empty, runt, crc and address cases and back-to-back bytes.
// Random records follow under two station addresses. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_ethernet_rx_ring_frame_check_core;
  import erfc_pkg::*;

  typedef struct {
    verdict_t    verdict;
    logic [15:0] ether_type;
    logic [15:0] payload_length;
    logic        dest_broadcast;
    logic [15:0] next_ring_offset;
    logic [15:0] read_pointer;
  } verdict_rec_t;

  typedef enum int {
    DST_BCAST,
    DST_OWN,
    DST_OTHER,
    DST_OWN_NEAR,
    DST_BCAST_NEAR
  } dest_kind_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [47:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_record_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_verdict;
  logic [15:0] out_ether_type;
  logic [15:0] out_payload_length;
  logic        out_dest_broadcast;
  logic [15:0] out_next_ring_offset;
  logic [15:0] out_read_pointer;

  verdict_rec_t verdict_q[$];
  logic [7:0]   frame_q[$];
  int           mismatch_cnt;
  bit           no_idle;

  // predictor state
  logic [47:0] station_mac;
  int unsigned rec_pos;
  logic [15:0] frm_len;
  logic [31:0] crc_acc;
  logic [31:0] tail4;
  bit          dst_own;
  bit          dst_bcast;
  logic [15:0] etype;
  logic [15:0] ring_off;

  ethernet_rx_ring_frame_check_core i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_record_byte       (in_record_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_verdict          (out_verdict),
    .out_ether_type       (out_ether_type),
    .out_payload_length   (out_payload_length),
    .out_dest_broadcast   (out_dest_broadcast),
    .out_next_ring_offset (out_next_ring_offset),
    .out_read_pointer     (out_read_pointer)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ((r[0] ^ b[k]) ? CRC_POLY : 32'h0);
    end
    return r;
  endfunction

  function automatic void restart_record();
    rec_pos   = 0;
    frm_len   = '0;
    crc_acc   = CRC_ONES;
    tail4     = '0;
    dst_own   = 1'b1;
    dst_bcast = 1'b1;
    etype     = '0;
  endfunction

  function automatic void predict_record_byte(logic [7:0] b);
    int unsigned  idx;
    int unsigned  unwrapped;
    logic [15:0]  nxt;
    logic [15:0]  rp;
    verdict_rec_t r;
    if (rec_pos < 4) begin
      if (rec_pos == 2) frm_len[7:0] = b;
      if (rec_pos == 3) frm_len[15:8] = b;
      rec_pos++;
      if (rec_pos == 4 && frm_len == 0) begin
        r = '{VD_EMPTY, 16'h0, 16'h0, 1'b0, ring_off, ring_off - RP_BIAS};
        verdict_q.push_back(r);
        restart_record();
      end
      return;
    end
    idx = rec_pos - 4;
    if (frm_len >= 4 && idx < int'(frm_len) - 4) crc_acc = crc32_step(crc_acc, b);
    if (idx < 6) begin
      if (b != station_mac[8*(5-idx) +: 8]) dst_own = 1'b0;
      if (b != 8'hFF) dst_bcast = 1'b0;
    end
    if (idx == 12) etype[15:8] = b;
    if (idx == 13) etype[7:0] = b;
    tail4 = {b, tail4[31:8]};
    rec_pos++;
    if (idx + 1 < frm_len) return;
    unwrapped = (int'(ring_off) + int'(frm_len) + 7) & ~32'd3;
    nxt = 16'(unwrapped % RING_BYTES);
    rp  = 16'(unwrapped - RP_BIAS);
    if (frm_len < MIN_FRAME) begin
      r = '{VD_RUNT, 16'h0, 16'h0, 1'b0, nxt, rp};
    end else begin
      if ((crc_acc ^ CRC_ONES) != tail4) r.verdict = VD_CRC;
      else if (!dst_bcast && !dst_own) r.verdict = VD_ADDR;
      else r.verdict = VD_ACCEPT;
      r.ether_type       = etype;
      r.payload_length   = frm_len - MIN_FRAME;
      r.dest_broadcast   = dst_bcast;
      r.next_ring_offset = nxt;
      r.read_pointer     = rp;
    end
    verdict_q.push_back(r);
    ring_off = nxt;
    restart_record();
  endfunction

  function automatic void build_frame(logic [15:0] len, dest_kind_t kind, bit corrupt);
    logic [31:0] fcs;
    int          k;
    frame_q.delete();
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    if (len >= MIN_FRAME) begin
      for (int i = 0; i < 6; i++) begin
        case (kind)
          DST_BCAST, DST_BCAST_NEAR: frame_q[i] = 8'hFF;
          DST_OWN, DST_OWN_NEAR:     frame_q[i] = station_mac[8*(5-i) +: 8];
          default: ;
        endcase
      end
      if (kind == DST_OWN_NEAR || kind == DST_BCAST_NEAR) begin
        k = $urandom_range(0, 5);
        frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
      end
      fcs = CRC_ONES;
      for (int i = 0; i < len - 4; i++) fcs = crc32_step(fcs, frame_q[i]);
      fcs = fcs ^ CRC_ONES;
      for (int i = 0; i < 4; i++) frame_q[len-4+i] = fcs[8*i +: 8];
    end
    if (corrupt && len > 0) begin
      k = $urandom_range(0, len - 1);
      frame_q[k] = frame_q[k] ^ (8'h1 << $urandom_range(0, 7));
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 50) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_record_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_record_byte(b);
  endtask

  task automatic send_frame(input logic [15:0] len, input dest_kind_t kind, input bit corrupt);
    build_frame(len, kind, corrupt);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mac(input logic [47:0] mac);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mac;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    station_mac = mac;
  endtask

  task automatic test_empty_and_runt();
    write_mac(rand_mac());
    send_frame(16'd0, DST_OTHER, 1'b0);
    send_frame(16'd0, DST_OTHER, 1'b0);
    send_frame(16'd1, DST_OTHER, 1'b0);
    send_frame(16'd3, DST_OTHER, 1'b0);
    send_frame(16'd4, DST_OTHER, 1'b0);
    send_frame(16'd17, DST_OTHER, 1'b0);
    drain();
  endtask

  task automatic test_frame_checks();
    send_frame(16'd18, DST_OWN, 1'b0);
    send_frame(16'd24, DST_BCAST, 1'b0);
    send_frame(16'd20, DST_OWN, 1'b0);
    send_frame(16'd20, DST_OTHER, 1'b0);
    send_frame(16'd20, DST_OWN, 1'b1);
    send_frame(16'd20, DST_OTHER, 1'b1);
    send_frame(16'd18, DST_OWN_NEAR, 1'b0);
    send_frame(16'd18, DST_BCAST_NEAR, 1'b0);
    drain();
  endtask

  task automatic test_mac_extremes();
    write_mac(48'h0);
    send_frame(16'd18, DST_OWN, 1'b0);
    send_frame(16'd18, DST_BCAST, 1'b0);
    drain();
    write_mac(48'hFFFF_FFFF_FFFF);
    send_frame(16'd18, DST_OWN, 1'b0);
    send_frame(16'd18, DST_OTHER, 1'b0);
    drain();
  endtask

  task automatic test_back_to_back();
    write_mac(rand_mac());
    no_idle = 1'b1;
    send_frame(16'd30, DST_OWN, 1'b0);
    send_frame(16'd18, DST_BCAST, 1'b0);
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic();
    int         sel;
    logic [15:0] len;
    for (int ph = 0; ph < 2; ph++) begin
      write_mac(rand_mac());
      for (int n = 0; n < 3; n++) begin
        no_idle = ($urandom_range(0, 4) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 8) len = 16'd0;
        else if (sel < 25) len = 16'($urandom_range(1, 17));
        else len = 16'($urandom_range(18, 40));
        send_frame(len, dest_kind_t'($urandom_range(0, 4)), $urandom_range(0, 4) == 0);
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  // result side: random stalls and per-field compare
  initial begin
    int           stall;
    verdict_rec_t want;
    stall = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("unexpected verdict %0d", out_verdict));
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict)
            report_mismatch($sformatf("verdict %0d expected %0d", out_verdict, want.verdict));
          if (out_ether_type !== want.ether_type)
            report_mismatch($sformatf("ether_type %h expected %h",
                                      out_ether_type, want.ether_type));
          if (out_payload_length !== want.payload_length)
            report_mismatch($sformatf("payload_length %0d expected %0d",
                                      out_payload_length, want.payload_length));
          if (out_dest_broadcast !== want.dest_broadcast)
            report_mismatch($sformatf("dest_broadcast %b expected %b",
                                      out_dest_broadcast, want.dest_broadcast));
          if (out_next_ring_offset !== want.next_ring_offset)
            report_mismatch($sformatf("next_ring_offset %h expected %h",
                                      out_next_ring_offset, want.next_ring_offset));
          if (out_read_pointer !== want.read_pointer)
            report_mismatch($sformatf("read_pointer %h expected %h",
                                      out_read_pointer, want.read_pointer));
        end
        stall = idle_cycles();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    mismatch_cnt = 0;
    no_idle      = 1'b0;
    station_mac  = '0;
    ring_off     = '0;
    restart_record();
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= '0;
    in_valid       <= 1'b0;
    in_record_byte <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_and_runt();
    test_frame_checks();
    test_mac_extremes();
    test_back_to_back();
    test_random_traffic();

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ethernet_rx_ring_frame_check_core.f =====
rtl/core/erfc_pkg.sv
rtl/core/ethernet_rx_ring_frame_check_core.sv
rtl/core/erfc_checker.sv
dv/tb_ethernet_rx_ring_frame_check_core.sv
